>>> hdl/ip_access_list_match_unit_assert.svh
// ----------------------------------------------------------------------------
// IP access list assertion macros
// Shared property shorthands for the access list match unit.
// ----------------------------------------------------------------------------
`ifndef IP_ACCESS_LIST_MATCH_UNIT_ASSERT_SVH
`define IP_ACCESS_LIST_MATCH_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IALM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define IALM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ialm_pkg.sv
// ----------------------------------------------------------------------------
// IP access list package
// Table size, field widths, codes and shared types.
// ----------------------------------------------------------------------------
package ialm_pkg;

    localparam int MAX_RULES = 1024;
    localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    localparam int ACTION_W  = 2;
    localparam int ADDR_W    = 64;
    localparam int MASK_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int DENY_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int PFX_W     = 8;
    localparam int V6_BITS   = 128;

    // upper word of addr_lo for a v4-mapped client ::ffff:a.b.c.d
    localparam logic [31:0] V4MAP_TAG = 32'h0000_FFFF;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CHECKED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [DENY_W-1:0]  t_dix;
    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              permit;
        logic              is_ipv6;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [MASK_W-1:0] mask;
    } t_rule;

    typedef struct packed {
        logic              native6;
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
    } t_client;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                allowed;
        t_dix                deny_index;
        t_count              rule_count;
    } t_rsp;

endpackage

>>> hdl/ialm_if.sv
// ----------------------------------------------------------------------------
// IP access list channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface ialm_req_if;
    logic                           valid;
    logic                           ready;
    logic [ialm_pkg::ACTION_W-1:0]  action;
    logic                           permit;
    logic                           is_ipv6;
    logic [ialm_pkg::ADDR_W-1:0]    addr_hi;
    logic [ialm_pkg::ADDR_W-1:0]    addr_lo;
    logic [ialm_pkg::MASK_W-1:0]    mask;

    modport source (output valid, action, permit, is_ipv6, addr_hi, addr_lo, mask,
                    input ready);
    modport sink   (input valid, action, permit, is_ipv6, addr_hi, addr_lo, mask,
                    output ready);
endinterface

interface ialm_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ialm_pkg::STATUS_W-1:0]  status;
    logic                           allowed;
    logic [ialm_pkg::DENY_W-1:0]    deny_index;
    logic [ialm_pkg::COUNT_W-1:0]   rule_count;

    modport source (output valid, status, allowed, deny_index, rule_count,
                    input ready);
    modport sink   (input valid, status, allowed, deny_index, rule_count,
                    output ready);
endinterface

>>> hdl/ialm_rule_match.sv
// ----------------------------------------------------------------------------
// IP access list rule compare
// Decides whether one stored rule matches the client address.
// ----------------------------------------------------------------------------
module ialm_rule_match (
    input  ialm_pkg::t_client i_client,
    input  ialm_pkg::t_rule   i_rule,
    output logic              o_hit
);

    logic [ialm_pkg::PFX_W-1:0]   pfx_len;
    logic [ialm_pkg::V6_BITS-1:0] pfx_mask;
    logic [ialm_pkg::V6_BITS-1:0] v6_diff;
    logic [31:0]                  v4_diff;
    logic                         v6_hit;
    logic                         v4_hit;

    always_comb begin
        // prefix length saturates at 128
        if (i_rule.mask > 32'(ialm_pkg::V6_BITS)) begin
            pfx_len = ialm_pkg::PFX_W'(ialm_pkg::V6_BITS);
        end else begin
            pfx_len = i_rule.mask[ialm_pkg::PFX_W-1:0];
        end
        if (pfx_len == '0) begin
            pfx_mask = '0;
        end else begin
            pfx_mask = {ialm_pkg::V6_BITS{1'b1}}
                       << (ialm_pkg::PFX_W'(ialm_pkg::V6_BITS) - pfx_len);
        end
        v6_diff = {i_client.addr_hi, i_client.addr_lo} ^ {i_rule.addr_hi, i_rule.addr_lo};
        v4_diff = i_client.addr_lo[31:0] ^ i_rule.addr_lo[31:0];
        v6_hit  = i_rule.is_ipv6 && ((v6_diff & pfx_mask) == '0);
        v4_hit  = !i_rule.is_ipv6 && ((v4_diff & i_rule.mask) == '0);
        o_hit   = i_client.native6 ? v6_hit : v4_hit;
    end

endmodule

>>> hdl/ip_access_list_match_unit.sv
// ----------------------------------------------------------------------------
// IP access list match unit
// Rule table in one synchronous memory; checks scan it one rule a cycle.
// ----------------------------------------------------------------------------
//  channel | side   | handshake      | payload
//  i_req   | sink   | valid / ready  | action, permit, is_ipv6, addr_hi, addr_lo, mask
//  o_rsp   | source | valid / ready  | status, allowed, deny_index, rule_count
//
//  Add, clear: the result goes through the response state into the output
//  register. Check: one memory read per rule, registered before the compare,
//  ending early when a permit rule hits; an empty table skips the scan.
//  One request at a time; the next is taken once the result sits in the
//  output register, even while that register is stalled.
//  Reset clears the rule count and control state only, and holds ready low;
//  entries at or above the count are never read, so there is no clearing pass.
// ----------------------------------------------------------------------------
module ip_access_list_match_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ialm_req_if.sink    i_req,
    ialm_rsp_if.source  o_rsp
);

    `include "ip_access_list_match_unit_assert.svh"

    ialm_pkg::t_state  r_state, n_state;
    ialm_pkg::t_cnt    r_total;
    ialm_pkg::t_client r_client;
    ialm_pkg::t_cnt    r_issue;
    logic              r_rd_vld;
    ialm_pkg::t_idx    r_rd_idx;
    ialm_pkg::t_rule   r_rd_rule;
    logic              r_denied;
    ialm_pkg::t_idx    r_dindex;
    ialm_pkg::t_rsp    r_res;
    logic              r_out_valid;
    ialm_pkg::t_rsp    r_out;

    ialm_pkg::t_rule   r_rule_mem [ialm_pkg::MAX_RULES];

    logic              req_ready;
    logic              accept;
    logic              tbl_full;
    logic              mem_we;
    logic              rd_en;
    logic              out_load;
    logic              hit;
    logic              permit_hit;
    logic              last_rule;
    logic              scan_done;
    logic              denied_nx;
    ialm_pkg::t_idx    dindex_nx;
    ialm_pkg::t_rule   wr_rule;
    ialm_pkg::t_client client_nx;

    ialm_rule_match u_match (
        .i_client (r_client),
        .i_rule   (r_rd_rule),
        .o_hit    (hit)
    );

    // ------------------------------------------------------------------------
    // Request decode and scan status
    // ------------------------------------------------------------------------
    always_comb begin
        tbl_full = (r_total >= ialm_pkg::t_cnt'(ialm_pkg::MAX_RULES));
        wr_rule  = '{permit:  i_req.permit,  is_ipv6: i_req.is_ipv6,
                     addr_hi: i_req.addr_hi, addr_lo: i_req.addr_lo,
                     mask:    i_req.mask};
        client_nx.native6 = i_req.is_ipv6 &&
                            !((i_req.addr_hi == '0) &&
                              (i_req.addr_lo[63:32] == ialm_pkg::V4MAP_TAG));
        client_nx.addr_hi = i_req.addr_hi;
        client_nx.addr_lo = i_req.addr_lo;

        permit_hit = r_rd_vld && hit && r_rd_rule.permit;
        last_rule  = (ialm_pkg::t_cnt'(r_rd_idx) == (r_total - 1'b1));
        scan_done  = r_rd_vld && (permit_hit || last_rule);

        denied_nx = r_denied;
        dindex_nx = r_dindex;
        if (r_rd_vld && hit) begin
            if (r_rd_rule.permit) begin
                denied_nx = 1'b0;
            end else begin
                denied_nx = 1'b1;
                dindex_nx = r_rd_idx;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Control FSM
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ialm_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_req.action)
                        ialm_pkg::ACT_ADD,
                        ialm_pkg::ACT_CLEAR: n_state = ialm_pkg::S_RESP;
                        ialm_pkg::ACT_CHECK: begin
                            n_state = (r_total == '0) ? ialm_pkg::S_RESP
                                                      : ialm_pkg::S_SCAN;
                        end
                        default:             n_state = ialm_pkg::S_IDLE;
                    endcase
                end
            end
            ialm_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = ialm_pkg::S_RESP;
                end
            end
            ialm_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = ialm_pkg::S_IDLE;
                end
            end
            default: n_state = ialm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        req_ready = (r_state == ialm_pkg::S_IDLE) && i_rst_n;
        accept    = i_req.valid && req_ready;
        // writes only happen in idle, reads only in scan: no same-entry overlap
        mem_we    = accept && (i_req.action == ialm_pkg::ACT_ADD) && !tbl_full;
        rd_en     = (r_state == ialm_pkg::S_SCAN) && (r_issue < r_total) && !scan_done;
        out_load  = (r_state == ialm_pkg::S_RESP) && (!r_out_valid || o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ialm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Rule memory
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rule_mem[r_total[ialm_pkg::IDX_W-1:0]] <= wr_rule;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_rule <= r_rule_mem[r_issue[ialm_pkg::IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------------
    // Table count, scan state, result
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (accept && (i_req.action == ialm_pkg::ACT_ADD) && !tbl_full) begin
                r_total <= r_total + 1'b1;
            end else if (accept && (i_req.action == ialm_pkg::ACT_CLEAR)) begin
                r_total <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_issue[ialm_pkg::IDX_W-1:0];
        if (rd_en) begin
            r_issue <= r_issue + 1'b1;
        end
        if (accept) begin
            r_client <= client_nx;
            r_issue  <= '0;
            r_denied <= 1'b0;
            r_dindex <= '0;
            r_res.deny_index <= '0;
            unique case (i_req.action)
                ialm_pkg::ACT_ADD: begin
                    r_res.allowed <= 1'b0;
                    if (tbl_full) begin
                        r_res.status     <= ialm_pkg::ST_FULL;
                        r_res.rule_count <= ialm_pkg::t_count'(r_total);
                    end else begin
                        r_res.status     <= ialm_pkg::ST_ADDED;
                        r_res.rule_count <= ialm_pkg::t_count'(r_total + 1'b1);
                    end
                end
                ialm_pkg::ACT_CLEAR: begin
                    r_res.allowed    <= 1'b0;
                    r_res.status     <= ialm_pkg::ST_CLEARED;
                    r_res.rule_count <= '0;
                end
                default: begin
                    // check; empty table answers allowed at once
                    r_res.status     <= ialm_pkg::ST_CHECKED;
                    r_res.allowed    <= 1'b1;
                    r_res.rule_count <= ialm_pkg::t_count'(r_total);
                end
            endcase
        end else if (r_state == ialm_pkg::S_SCAN) begin
            r_denied <= denied_nx;
            r_dindex <= dindex_nx;
            if (scan_done) begin
                r_res.allowed    <= !denied_nx;
                r_res.deny_index <= denied_nx ? ialm_pkg::t_dix'(dindex_nx) : '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign i_req.ready      = req_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.allowed    = r_out.allowed;
    assign o_rsp.deny_index = r_out.deny_index;
    assign o_rsp.rule_count = r_out.rule_count;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `IALM_ASSERT_NOW(a_total_bound, 1'b1,
        r_total <= ialm_pkg::t_cnt'(ialm_pkg::MAX_RULES), "rule count above table size")
    `IALM_ASSERT_NOW(a_read_in_table, rd_en, r_issue < r_total,
        "rule read beyond stored rules")
    `IALM_ASSERT_NOW(a_no_write_in_scan, r_state == ialm_pkg::S_SCAN, !mem_we,
        "rule write during scan")
    `IALM_ASSERT_NEXT(a_scan_to_resp, (r_state == ialm_pkg::S_SCAN) && scan_done,
        r_state == ialm_pkg::S_RESP, "scan end did not reach response")
    `IALM_ASSERT_NOW(a_deny_in_range,
        r_out_valid && (r_out.status == ialm_pkg::ST_CHECKED) && !r_out.allowed,
        r_out.deny_index < r_out.rule_count, "deny index outside rule table")

endmodule

>>> tb/sv/ip_access_list_match_unit_test.sv
// ----------------------------------------------------------------------------
// IP access list match unit testbench
// Drives add, check and clear requests, keeps its own copy of the rule table,
// predicts each response and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module ip_access_list_match_unit_test;

    localparam int LIMIT        = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 580;
    localparam int BIG_TABLE    = 40;

    typedef struct packed {
        logic [ialm_pkg::ACTION_W-1:0] action;
        logic                          permit;
        logic                          is_ipv6;
        logic [ialm_pkg::ADDR_W-1:0]   addr_hi;
        logic [ialm_pkg::ADDR_W-1:0]   addr_lo;
        logic [ialm_pkg::MASK_W-1:0]   mask;
    } t_acl_req;

    class acl_scoreboard;
        ialm_pkg::t_rule rules[ialm_pkg::MAX_RULES];
        int              rule_total;
        ialm_pkg::t_rsp  awaited[$];
        int              mismatches;

        function new();
            rule_total = 0;
            mismatches = 0;
        endfunction

        // first matching permit wins, else the last matching deny
        function void acl_verdict(input t_acl_req c, output logic allowed,
                                  output ialm_pkg::t_dix idx);
            logic            native6;
            logic            hit;
            logic            denied;
            logic [127:0]    m;
            int unsigned     n;
            ialm_pkg::t_rule rl;
            native6 = c.is_ipv6 &&
                      !(c.addr_hi == '0 && c.addr_lo[63:32] == ialm_pkg::V4MAP_TAG);
            denied  = 1'b0;
            idx     = '0;
            for (int i = 0; i < rule_total; i++) begin
                rl = rules[i];
                if (rl.is_ipv6 != native6)
                    continue;
                if (native6) begin
                    n   = (rl.mask > ialm_pkg::V6_BITS) ? ialm_pkg::V6_BITS : rl.mask;
                    m   = (n == 0) ? '0 : ({128{1'b1}} << (ialm_pkg::V6_BITS - n));
                    hit = ((({c.addr_hi, c.addr_lo} ^ {rl.addr_hi, rl.addr_lo}) & m) == '0);
                end else begin
                    hit = (((c.addr_lo[31:0] ^ rl.addr_lo[31:0]) & rl.mask) == '0);
                end
                if (!hit)
                    continue;
                if (rl.permit) begin
                    denied = 1'b0;
                    break;
                end
                denied = 1'b1;
                idx    = ialm_pkg::t_dix'(i);
            end
            allowed = !denied;
            if (!denied)
                idx = '0;
        endfunction

        function void note_request(t_acl_req r);
            ialm_pkg::t_rsp want;
            if (r.action == ialm_pkg::ACT_NOP)
                return;
            want = '0;
            case (r.action)
                ialm_pkg::ACT_ADD: begin
                    if (rule_total >= ialm_pkg::MAX_RULES) begin
                        want.status = ialm_pkg::ST_FULL;
                    end else begin
                        rules[rule_total] = ialm_pkg::t_rule'{r.permit, r.is_ipv6,
                                                              r.addr_hi, r.addr_lo,
                                                              r.mask};
                        rule_total++;
                        want.status = ialm_pkg::ST_ADDED;
                    end
                end
                ialm_pkg::ACT_CLEAR: begin
                    rule_total  = 0;
                    want.status = ialm_pkg::ST_CLEARED;
                end
                default: begin
                    want.status = ialm_pkg::ST_CHECKED;
                    acl_verdict(r, want.allowed, want.deny_index);
                end
            endcase
            want.rule_count = ialm_pkg::t_count'(rule_total);
            awaited.push_back(want);
        endfunction

        function void report(string what, ialm_pkg::t_rsp want, ialm_pkg::t_rsp got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected status=%0d allowed=%0d deny_index=%0d rule_count=%0d,%s",
                         what, want.status, want.allowed, want.deny_index, want.rule_count,
                         $sformatf(" got status=%0d allowed=%0d deny_index=%0d rule_count=%0d",
                                   got.status, got.allowed, got.deny_index, got.rule_count));
        endfunction

        function void check_result(ialm_pkg::t_rsp got);
            ialm_pkg::t_rsp want;
            if (awaited.size() == 0) begin
                report("response with nothing pending", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.allowed !== want.allowed ||
                got.deny_index !== want.deny_index || got.rule_count !== want.rule_count)
                report("response mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ialm_req_if req_if ();
    ialm_rsp_if rsp_if ();

    ip_access_list_match_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    acl_scoreboard sb;
    int            send_idle_pct = 17;
    int            rsp_idle_pct  = 73;
    int            items_sent    = 0;
    int            cycle_count   = 0;
    int            hold_left     = 0;
    bit            hold_arm      = 1'b0;
    bit            hold_done     = 1'b0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // response side: check what was taken, then pick ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(ialm_pkg::t_rsp'{rsp_if.status, rsp_if.allowed,
                                             rsp_if.deny_index, rsp_if.rule_count});
        if (hold_arm && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    function automatic t_acl_req random_item(input logic [ialm_pkg::ACTION_W-1:0] act);
        t_acl_req r;
        r.action  = act;
        r.permit  = 1'($urandom_range(1));
        r.is_ipv6 = 1'($urandom_range(1));
        r.addr_hi = {$urandom, $urandom};
        r.addr_lo = {$urandom, $urandom};
        r.mask    = $urandom;
        return r;
    endfunction

    function automatic t_acl_req random_rule();
        t_acl_req r;
        int       n;
        r = random_item(ialm_pkg::ACT_ADD);
        if (r.is_ipv6) begin
            case ($urandom_range(9))
                0: r.mask = $urandom_range(129, 255);
                1: r.mask = $urandom;
                default: r.mask = $urandom_range(0, ialm_pkg::V6_BITS);
            endcase
        end else begin
            n = $urandom_range(0, 32);
            case ($urandom_range(4))
                0: r.mask = $urandom;
                1: r.mask = '1;
                2: r.mask = '0;
                default: r.mask = (n == 0) ? '0 : (32'hFFFF_FFFF << (32 - n));
            endcase
        end
        return r;
    endfunction

    // aim = build a client that falls inside a stored rule
    function automatic t_acl_req client_for(input bit aim);
        t_acl_req        c;
        ialm_pkg::t_rule rl;
        logic [127:0]    m;
        int unsigned     n;
        c = random_item(ialm_pkg::ACT_CHECK);
        if (aim && sb.rule_total > 0) begin
            rl = sb.rules[$urandom_range(sb.rule_total - 1)];
            if (rl.is_ipv6) begin
                n = (rl.mask > ialm_pkg::V6_BITS) ? ialm_pkg::V6_BITS : rl.mask;
                m = (n == 0) ? '0 : ({128{1'b1}} << (ialm_pkg::V6_BITS - n));
                {c.addr_hi, c.addr_lo} = ({rl.addr_hi, rl.addr_lo} & m) |
                                         ({c.addr_hi, c.addr_lo} & ~m);
                c.is_ipv6 = 1'b1;
            end else begin
                c.addr_lo[31:0] = (rl.addr_lo[31:0] & rl.mask) | (c.addr_lo[31:0] & ~rl.mask);
                c.is_ipv6 = 1'($urandom_range(1));
                if (c.is_ipv6) begin
                    c.addr_hi        = '0;
                    c.addr_lo[63:32] = ialm_pkg::V4MAP_TAG;
                end
            end
        end else begin
            case ($urandom_range(3))
                0: begin
                    c.is_ipv6        = 1'b1;
                    c.addr_hi        = '0;
                    c.addr_lo[63:32] = ialm_pkg::V4MAP_TAG;
                end
                1: begin
                    // one bit away from the v4-mapped form
                    c.is_ipv6        = 1'b1;
                    c.addr_hi        = '0;
                    c.addr_lo[63:32] = ialm_pkg::V4MAP_TAG ^ (32'h1 << $urandom_range(31));
                    if ($urandom_range(1)) begin
                        c.addr_lo[63:32] = ialm_pkg::V4MAP_TAG;
                        c.addr_hi        = 64'h1 << $urandom_range(63);
                    end
                end
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic send_request(input t_acl_req r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= r.action;
        req_if.permit  <= r.permit;
        req_if.is_ipv6 <= r.is_ipv6;
        req_if.addr_hi <= r.addr_hi;
        req_if.addr_lo <= r.addr_lo;
        req_if.mask    <= r.mask;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        if (r.action != ialm_pkg::ACT_NOP)
            items_sent++;
    endtask

    task automatic run_phase(input int tx_idle, input int rx_idle, input int budget,
                             input bit with_hold);
        int start;
        int pick;
        send_idle_pct = tx_idle;
        rsp_idle_pct  = rx_idle;
        start         = items_sent;
        if (with_hold)
            hold_arm = 1'b1;
        while (items_sent - start < budget) begin
            pick = $urandom_range(99);
            if (sb.rule_total > BIG_TABLE) begin
                send_request(random_item(ialm_pkg::ACT_CLEAR));
            end else if (pick < 70) begin
                if ($urandom_range(2) == 0)
                    send_request(random_item(ialm_pkg::ACT_CLEAR));
                repeat ($urandom_range(0, 8)) send_request(random_rule());
                repeat ($urandom_range(1, 5)) send_request(client_for($urandom_range(9) < 7));
            end else if (pick < 85) begin
                send_request(random_item(ialm_pkg::ACTION_W'($urandom_range(3))));
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 3)) send_request(client_for(1'b0));
                send_request(random_item(ialm_pkg::ACT_CLEAR));
                send_request(client_for(1'b0));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(random_rule());
                    if ($urandom_range(1))
                        send_request(random_item(ialm_pkg::ACT_NOP));
                end
            end
        end
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.action  = ialm_pkg::ACT_NOP;
        req_if.permit  = 1'b0;
        req_if.is_ipv6 = 1'b0;
        req_if.addr_hi = '0;
        req_if.addr_lo = '0;
        req_if.mask    = '0;
        rsp_if.ready   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, ignored action, then a small mixed table
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b0, 64'h0, 64'h0, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_NOP, 1'b1, 1'b1, '1, '1, '1});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b0, 1'b0, 64'h0, 64'h0A00_0000,
                                32'hFF00_0000});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b1, 1'b0, 64'h0, 64'h0A01_0000,
                                32'hFFFF_0000});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b0, 1'b0, 64'h0, 64'h0A01_0200,
                                32'hFFFF_FF00});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b0, 1'b1, '1, '1, 32'd0});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b1, 1'b1, 64'h2001_0DB8_0000_0000,
                                64'h0, 32'd32});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b0, 1'b1, 64'hFD00_1234_5678_9ABC,
                                64'hDEF0_1357_9BDF_2468, 32'd200});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b0, 1'b1, '1, 64'h0, 32'd64});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b0, 64'h0, 64'h0A02_0304,
                                32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b0, 64'h0, 64'h0A01_0203,
                                32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b1, 64'h0,
                                64'h0000_FFFF_0A02_0304, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b1, 64'h0,
                                64'hFFFF_FFFE_0A02_0304, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b1, 64'hFD00_1234_5678_9ABC,
                                64'hDEF0_1357_9BDF_2468, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b1, 64'hFD00_1234_5678_9ABC,
                                64'hDEF0_1357_9BDF_2469, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b1, 64'h2001_0DB8_0000_0001,
                                64'h1234_5678_9ABC_DEF0, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b1, '1, 64'h0, 32'h0});
        // IPv4 client with junk in the unused upper bits
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b1, 1'b0, '1,
                                64'hFFFF_FFFF_C0A8_0001, '1});
        send_request(t_acl_req'{ialm_pkg::ACT_ADD, 1'b1, 1'b0, '1, '1, '1});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b0, 64'h0,
                                64'h0000_0000_FFFF_FFFF, 32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_CLEAR, 1'b1, 1'b1, '1, '1, '1});
        send_request(t_acl_req'{ialm_pkg::ACT_CHECK, 1'b0, 1'b0, 64'h0, 64'h0A02_0304,
                                32'h0});
        send_request(t_acl_req'{ialm_pkg::ACT_NOP, 1'b0, 1'b0, 64'h0, 64'h0, 32'h0});

        run_phase(17, 73, RANDOM_ITEMS / 3, 1'b0);
        run_phase(73, 17, RANDOM_ITEMS / 3, 1'b0);
        run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 1'b1);
        req_if.valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ialm_pkg.sv
hdl/ialm_if.sv
hdl/ialm_rule_match.sv
hdl/ip_access_list_match_unit.sv
tb/sv/ip_access_list_match_unit_test.sv
